// ===== rtl/bint_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bint_pkg
// Shared types and constants for the eased blend interpolator.
// ----------------------------------------------------------------------------
package bint_pkg;

  // weight and easing factor are Q0.16 with one extra bit for exactly 1.0
  localparam int unsigned WEIGHT_W = 17;
  localparam int unsigned MODE_W   = 3;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

  typedef enum logic [MODE_W-1:0] {
    MODE_TRUNC   = 3'd0,
    MODE_LINEAR  = 3'd1,
    MODE_COSINE  = 3'd2,
    MODE_CUBIC   = 3'd3,
    MODE_QUINTIC = 3'd4
  } mode_e;

endpackage

// ===== rtl/bint_cos_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bint_cos_rom
// Raised-cosine easing table, (1 - cos(pi*u)) / 2 in Q0.16, registered read.
// ----------------------------------------------------------------------------
module bint_cos_rom #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [$clog2(DEPTH)-1:0]      addr_i,
  output logic [bint_pkg::WEIGHT_W-1:0] data_o
);
  import bint_pkg::*;

  localparam logic [63:0] CosLast = 64'(DEPTH - 1);
  localparam logic [63:0] CosHalf = CosLast / 64'd2;
  localparam logic [63:0] PiQ30   = 64'd3373259426;
  localparam logic [63:0] Q30One  = 64'd1 << 30;

  // Taylor divisors 2j*(2j-1) for j = 2 .. 7
  localparam logic [7:0] TaylorDiv [2:7] = '{8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182};

  function automatic logic [WEIGHT_W-1:0] cos_entry(input int unsigned k);
    logic        mir;
    logic [63:0] kk;
    logic [63:0] theta;
    logic [63:0] x2;
    logic [63:0] q;
    logic [63:0] t;
    mir   = (64'(k) << 1) > CosLast;
    kk    = mir ? (CosLast - 64'(k)) : 64'(k);
    theta = (PiQ30 * kk + CosHalf) / CosLast;
    x2    = (theta * theta + (64'd1 << 29)) >> 30;
    q     = Q30One;
    for (int j = 7; j >= 2; j--) begin
      q = Q30One - (((x2 * q) >> 30) / 64'(TaylorDiv[j]));
    end
    t = (x2 * q + (64'd1 << 45)) >> 46;
    if (t > 64'd32768) begin
      t = 64'd32768;
    end
    return mir ? (WEIGHT_ONE - WEIGHT_W'(t)) : WEIGHT_W'(t);
  endfunction

  logic [WEIGHT_W-1:0] rom [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_rom
    assign rom[g] = cos_entry(g);
  end

  logic [WEIGHT_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= rom[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// ===== rtl/bint_ease.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bint_ease
// Six-stage easing pipeline: weight in, easing factor t, a and b - a out.
// ----------------------------------------------------------------------------
module bint_ease #(
  parameter int unsigned VALUE_WIDTH     = 16,
  parameter int unsigned COS_TABLE_DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [VALUE_WIDTH-1:0] a_i,
  input  logic signed [VALUE_WIDTH-1:0] b_i,
  input  logic [bint_pkg::WEIGHT_W-1:0] w_i,
  input  bint_pkg::mode_e               mode_i,
  output logic                          valid_o,
  output logic signed [VALUE_WIDTH-1:0] a_o,
  output logic signed [VALUE_WIDTH:0]   d_o,
  output logic [bint_pkg::WEIGHT_W-1:0] t_o
);
  import bint_pkg::*;

  localparam int unsigned IdxW = $clog2(COS_TABLE_DEPTH);
  localparam int unsigned KPW  = IdxW + WEIGHT_W;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef logic signed [VALUE_WIDTH:0]   diff_t;
  typedef logic [WEIGHT_W-1:0]           wt_t;

  // valid bits
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  // payload carried alongside
  val_t  a1_q, a2_q, a3_q, a4_q, a5_q, a6_q;
  diff_t d1_q, d2_q, d3_q, d4_q, d5_q, d6_q;
  wt_t   w1_q, w2_q, w3_q, w4_q, w5_q;
  wt_t   cos2, cos3_q, cos4_q, cos5_q;
  logic [IdxW-1:0] k1_q;
  logic [32:0] sq2_q;
  logic [49:0] cube3_q;
  logic [48:0] cub3_q;
  logic [35:0] p3_q, p4_q;
  logic [24:0] c4_q;
  wt_t         tc4_q, tc5_q;
  logic [42:0] pph5_q, ppl5_q;
  wt_t         t6_q;

  // stage 1: saturate weight, table index
  wt_t             w_sat;
  logic [KPW-1:0]  kprod;
  always_comb begin
    w_sat = (w_i > WEIGHT_ONE) ? WEIGHT_ONE : w_i;
    kprod = KPW'(w_sat) * KPW'(COS_TABLE_DEPTH - 1) + KPW'(32768);
  end

  // stage 3: cube, cubic product, quintic polynomial
  logic [49:0] cube_d;
  logic [48:0] cub_d;
  logic [17:0] cub_f;
  logic [37:0] p_d;
  always_comb begin
    cube_d = 50'(sq2_q) * 50'(w2_q);
    cub_f  = 18'(196608) - {w2_q, 1'b0};
    cub_d  = 49'(50'(sq2_q) * 50'(cub_f));
    p_d    = (38'(sq2_q) << 2) + (38'(sq2_q) << 1) + (38'd10 << 32)
           - ((38'(w2_q) << 20) - (38'(w2_q) << 16));
  end

  // stage 4: round cube and cubic result
  logic [50:0] cube_r;
  logic [49:0] cub_r;
  always_comb begin
    cube_r = 51'(cube3_q) + (51'd1 << 23);
    cub_r  = 50'(cub3_q) + (50'd1 << 31);
  end

  // stage 6: assemble quintic product, clamp, pick by mode
  logic [60:0] prod;
  logic [20:0] tq;
  wt_t         tq_sat;
  wt_t         t_d;
  always_comb begin
    prod   = (61'(pph5_q) << 18) + 61'(ppl5_q) + (61'd1 << 39);
    tq     = prod[60:40];
    tq_sat = (tq > 21'(WEIGHT_ONE)) ? WEIGHT_ONE : tq[WEIGHT_W-1:0];
    unique case (mode_i)
      MODE_TRUNC:   t_d = '0;
      MODE_LINEAR:  t_d = w5_q;
      MODE_COSINE:  t_d = cos5_q;
      MODE_CUBIC:   t_d = tc5_q;
      MODE_QUINTIC: t_d = tq_sat;
      default:      t_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1
      a1_q    <= a_i;
      d1_q    <= diff_t'(b_i) - diff_t'(a_i);
      w1_q    <= w_sat;
      k1_q    <= kprod[IdxW+15:16];
      // stage 2
      a2_q    <= a1_q;
      d2_q    <= d1_q;
      w2_q    <= w1_q;
      sq2_q   <= 33'(34'(w1_q) * 34'(w1_q));
      // stage 3
      a3_q    <= a2_q;
      d3_q    <= d2_q;
      w3_q    <= w2_q;
      cos3_q  <= cos2;
      cube3_q <= cube_d;
      cub3_q  <= cub_d;
      p3_q    <= p_d[35:0];
      // stage 4
      a4_q    <= a3_q;
      d4_q    <= d3_q;
      w4_q    <= w3_q;
      cos4_q  <= cos3_q;
      c4_q    <= cube_r[48:24];
      tc4_q   <= cub_r[48:32];
      p4_q    <= p3_q;
      // stage 5: quintic product in two halves
      a5_q    <= a4_q;
      d5_q    <= d4_q;
      w5_q    <= w4_q;
      cos5_q  <= cos4_q;
      tc5_q   <= tc4_q;
      pph5_q  <= 43'(c4_q) * 43'(p4_q[35:18]);
      ppl5_q  <= 43'(c4_q) * 43'(p4_q[17:0]);
      // stage 6
      a6_q    <= a5_q;
      d6_q    <= d5_q;
      t6_q    <= t_d;
    end
  end

  bint_cos_rom #(
    .DEPTH (COS_TABLE_DEPTH)
  ) u_cos_rom (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .addr_i (k1_q),
    .data_o (cos2)
  );

  assign valid_o = v6_q;
  assign a_o     = a6_q;
  assign d_o     = d6_q;
  assign t_o     = t6_q;

  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v6_q |-> t6_q <= WEIGHT_ONE)
    else $error("easing factor above one");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> 32'(k1_q) <= 32'(COS_TABLE_DEPTH - 1))
    else $error("cosine index beyond table");

  a_valid_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && v5_q |=> v6_q)
    else $error("item lost between stages 5 and 6");

endmodule

// ===== rtl/bint_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bint_blend
// Blend stages: a + (b - a) * t, rounded to nearest, into the output register.
// ----------------------------------------------------------------------------
module bint_blend #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [VALUE_WIDTH-1:0] a_i,
  input  logic signed [VALUE_WIDTH:0]   d_i,
  input  logic [bint_pkg::WEIGHT_W-1:0] t_i,
  output logic                          valid_o,
  output logic signed [VALUE_WIDTH-1:0] value_o
);
  import bint_pkg::*;

  localparam int unsigned SW = VALUE_WIDTH + WEIGHT_W + 2;

  typedef logic signed [SW-1:0] sum_t;

  logic                          v7_q, v8_q;
  logic signed [VALUE_WIDTH-1:0] a7_q;
  sum_t                          m7_q;
  logic signed [VALUE_WIDTH-1:0] out_q;

  sum_t m_d;
  sum_t s_d;
  always_comb begin
    m_d = sum_t'(d_i) * sum_t'($signed({1'b0, t_i}));
    // floor((a*2^16 + m + 2^15) / 2^16)
    s_d = m7_q + (sum_t'(a7_q) <<< 16) + sum_t'(32768);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (en_i) begin
      v7_q <= valid_i;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a7_q  <= a_i;
      m7_q  <= m_d;
      out_q <= s_d[VALUE_WIDTH+15:16];
    end
  end

  assign valid_o = v8_q;
  assign value_o = out_q;

endmodule

// ===== rtl/blend_interpolator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blend_interpolator_top
// Eased interpolation a*(1-t) + b*t with truncate, linear, cosine, cubic and
// quintic easing of a Q0.16 weight.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry start_value_i, end_value_i and
// blend_weight_i (Q0.16, values above 1.0 saturate). An item is taken at an
// edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i carry blended_value_o, one result
// per item, in order.
// Mode register: cfg_valid_i / cfg_ready_o with cfg_data_i; always ready.
// Write it only while no item is in flight.
// out_valid_o follows acceptance through the eight register stages: input,
// squaring/table read, cube and polynomial, rounding, split quintic product,
// mode select, blend multiply, rounding into the output register. One item
// per cycle is sustained while the output is not stalled.
// A stalled output freezes the whole pipeline; in_stall_o then rises in the
// same cycle, so nothing is dropped or repeated.
// Reset empties the pipeline and sets the mode to linear.
// ----------------------------------------------------------------------------
module blend_interpolator_top #(
  parameter int unsigned VALUE_WIDTH     = 16,
  parameter int unsigned COS_TABLE_DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bint_pkg::MODE_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0] start_value_i,
  input  logic signed [VALUE_WIDTH-1:0] end_value_i,
  input  logic [bint_pkg::WEIGHT_W-1:0] blend_weight_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [VALUE_WIDTH-1:0] blended_value_o
);
  import bint_pkg::*;

  mode_e mode_q;
  logic  adv;

  logic                          e_valid;
  logic signed [VALUE_WIDTH-1:0] e_a;
  logic signed [VALUE_WIDTH:0]   e_d;
  logic [WEIGHT_W-1:0]           e_t;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LINEAR;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= mode_e'(cfg_data_i);
    end
  end

  assign cfg_ready_o = 1'b1;

  // whole pipeline moves unless a result is held at the output
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  bint_ease #(
    .VALUE_WIDTH     (VALUE_WIDTH),
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
  ) u_ease (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .a_i     (start_value_i),
    .b_i     (end_value_i),
    .w_i     (blend_weight_i),
    .mode_i  (mode_q),
    .valid_o (e_valid),
    .a_o     (e_a),
    .d_o     (e_d),
    .t_o     (e_t)
  );

  bint_blend #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (e_valid),
    .a_i     (e_a),
    .d_i     (e_d),
    .t_i     (e_t),
    .valid_o (out_valid_o),
    .value_o (blended_value_o)
  );

endmodule

// ===== dv/tb_blend_interpolator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_blend_interpolator_top
// Self-checking bench for the eased blend interpolator. A directed table
// covers endpoint and weight extremes, rounding ties, weight saturation and
// every easing mode, unused modes included. Random items then run through
// several mode settings under varying idle and stall patterns. Each result is
// checked against the listed value or an integer model of easing and blend.
// ----------------------------------------------------------------------------
module tb_blend_interpolator_top;
  import bint_pkg::*;

  localparam int unsigned VALUE_WIDTH     = 16;
  localparam int unsigned COS_TABLE_DEPTH = 256;
  localparam int unsigned TAIL_CYCLES     = 20;
  localparam int unsigned PHASE_ITEMS     = 200;
  localparam int unsigned PHASES          = 10;

  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  typedef struct packed {
    logic [MODE_W-1:0]      mode;
    logic [VALUE_WIDTH-1:0] start_v;
    logic [VALUE_WIDTH-1:0] end_v;
    logic [WEIGHT_W-1:0]    weight;
    logic                   known;
    logic [VALUE_WIDTH-1:0] result;
  } blend_vector_t;

  typedef struct {
    logic [MODE_W-1:0]      mode;
    logic [VALUE_WIDTH-1:0] start_v;
    logic [VALUE_WIDTH-1:0] end_v;
    logic [WEIGHT_W-1:0]    weight;
    logic [VALUE_WIDTH-1:0] result;
  } pending_blend_t;

  localparam int unsigned N_DIRECTED = 23;
  localparam blend_vector_t DIRECTED [N_DIRECTED] = '{
    '{MODE_LINEAR,  16'sh8000,  16'sh7FFF,  17'd0,      1'b1, 16'sh8000},
    '{MODE_LINEAR,  16'sh8000,  16'sh7FFF,  17'h10000,  1'b1, 16'sh7FFF},
    '{MODE_LINEAR,  16'sh7FFF,  16'sh8000,  17'h10000,  1'b1, 16'sh8000},
    '{MODE_LINEAR,  16'sh7FFF,  16'sh8000,  17'h1FFFF,  1'b1, 16'sh8000},
    // half-way ties round towards +infinity
    '{MODE_LINEAR,  16'sd0,     16'sd1,     17'h08000,  1'b1, 16'sd1},
    '{MODE_LINEAR,  16'sd0,     -16'sd1,    17'h08000,  1'b1, 16'sd0},
    '{MODE_LINEAR,  16'sh8000,  16'sh7FFF,  17'h08000,  1'b1, 16'sd0},
    '{MODE_LINEAR,  16'sd1000,  -16'sd1000, 17'd16384,  1'b0, 16'sd0},
    '{MODE_TRUNC,   16'sd12345, 16'sh8000,  17'd40000,  1'b1, 16'sd12345},
    '{MODE_TRUNC,   16'sh8000,  16'sh7FFF,  17'h1FFFF,  1'b1, 16'sh8000},
    '{MODE_COSINE,  16'sh8000,  16'sh7FFF,  17'd0,      1'b1, 16'sh8000},
    '{MODE_COSINE,  16'sh8000,  16'sh7FFF,  17'h10000,  1'b1, 16'sh7FFF},
    // table index right at the mirror point
    '{MODE_COSINE,  16'sd100,   -16'sd100,  17'h08000,  1'b0, 16'sd0},
    '{MODE_COSINE,  16'sd0,     16'sd30000, 17'd257,    1'b0, 16'sd0},
    '{MODE_COSINE,  16'sh7FFF,  16'sh8000,  17'h10001,  1'b1, 16'sh8000},
    '{MODE_CUBIC,   16'sh7FFF,  16'sh8000,  17'd0,      1'b1, 16'sh7FFF},
    '{MODE_CUBIC,   16'sh7FFF,  16'sh8000,  17'h10000,  1'b1, 16'sh8000},
    '{MODE_CUBIC,   -16'sd20000, 16'sd20000, 17'd12000, 1'b0, 16'sd0},
    '{MODE_QUINTIC, 16'sh8000,  16'sh7FFF,  17'h10000,  1'b1, 16'sh7FFF},
    '{MODE_QUINTIC, 16'sd5,     -16'sd7,    17'd1,      1'b0, 16'sd0},
    '{MODE_QUINTIC, 16'sh8000,  16'sh7FFF,  17'd33000,  1'b0, 16'sd0},
    // unused modes pass the start value through
    '{MODE_UNUSED_HI, -16'sd5,  16'sd9,     17'd30000,  1'b1, -16'sd5},
    '{MODE_UNUSED_LO, 16'sh7FFF, 16'sd0,    17'h10000,  1'b1, 16'sh7FFF}
  };

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          cfg_valid_i     = 1'b0;
  logic                          cfg_ready_o;
  logic [MODE_W-1:0]             cfg_data_i      = '0;
  logic                          in_valid_i      = 1'b0;
  logic                          in_stall_o;
  logic signed [VALUE_WIDTH-1:0] start_value_i   = '0;
  logic signed [VALUE_WIDTH-1:0] end_value_i     = '0;
  logic [WEIGHT_W-1:0]           blend_weight_i  = '0;
  logic                          out_valid_o;
  logic                          out_stall_i     = 1'b0;
  logic signed [VALUE_WIDTH-1:0] blended_value_o;

  logic [MODE_W-1:0] blend_mode     = MODE_LINEAR;
  int                send_idle_pct  = 8;
  int                recv_stall_pct = 83;
  int                mismatch_count = 0;
  pending_blend_t    pending_blends [$];

  blend_interpolator_top #(
    .VALUE_WIDTH    (VALUE_WIDTH),
    .COS_TABLE_DEPTH(COS_TABLE_DEPTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .start_value_i  (start_value_i),
    .end_value_i    (end_value_i),
    .blend_weight_i (blend_weight_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .blended_value_o(blended_value_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // (1 - cos(pi*u)) / 2 table entry, polynomial cosine in Q2.30
  function automatic longint unsigned cosine_entry(input longint unsigned idx);
    longint unsigned n, k, theta, x2, q, t;
    logic            mirror;
    n      = COS_TABLE_DEPTH - 1;
    k      = idx;
    mirror = (2 * k) > n;
    if (mirror) k = n - k;
    theta = (PI_Q30 * k + n / 2) / n;
    x2    = (theta * theta + (64'd1 << 29)) >> 30;
    q     = Q30_ONE;
    for (int j = 7; j >= 2; j--) begin
      q = Q30_ONE - ((x2 * q) >> 30) / longint'((2 * j) * (2 * j - 1));
    end
    t = (x2 * q + (64'd1 << 45)) >> 46;
    if (t > 64'd32768) t = 64'd32768;
    return mirror ? (64'd65536 - t) : t;
  endfunction

  function automatic longint unsigned easing_factor(input logic [MODE_W-1:0] mode,
                                                    input longint unsigned w);
    longint unsigned c, p, t;
    case (mode)
      MODE_LINEAR: return w;
      MODE_COSINE: return cosine_entry((w * (COS_TABLE_DEPTH - 1) + 64'd32768) >> 16);
      MODE_CUBIC:  return (w * w * (64'd196608 - 2 * w) + (64'd1 << 31)) >> 32;
      MODE_QUINTIC: begin
        c = (w * w * w + (64'd1 << 23)) >> 24;
        p = 6 * w * w + (64'd10 << 32) - 64'd983040 * w;
        t = (c * p + (64'd1 << 39)) >> 40;
        return (t > 64'd65536) ? 64'd65536 : t;
      end
      default: return 64'd0;
    endcase
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] eased_blend(
    input logic [MODE_W-1:0]             mode,
    input logic signed [VALUE_WIDTH-1:0] a,
    input logic signed [VALUE_WIDTH-1:0] b,
    input logic [WEIGHT_W-1:0]           weight
  );
    longint          av, bv, t, s, r;
    longint unsigned w;
    av = a;
    bv = b;
    w  = weight;
    if (w > 64'd65536) w = 64'd65536;
    if (mode == MODE_TRUNC || mode > MODE_QUINTIC) return a;
    t = longint'(easing_factor(mode, w));
    s = av * (64'sd65536 - t) + bv * t;
    r = (s + 64'sd32768) >>> 16;
    return r[VALUE_WIDTH-1:0];
  endfunction

  // Called at a rising edge; returns at the edge that took the write.
  task automatic write_mode(input logic [MODE_W-1:0] mode);
    in_valid_i <= 1'b0;
    while (pending_blends.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    blend_mode  = mode;
  endtask

  // Called at a rising edge; valid is left high, the next call decides.
  task automatic send_blend(input logic signed [VALUE_WIDTH-1:0] a,
                            input logic signed [VALUE_WIDTH-1:0] b,
                            input logic [WEIGHT_W-1:0]           weight,
                            input logic                          known,
                            input logic [VALUE_WIDTH-1:0]        result);
    pending_blend_t entry;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    start_value_i  <= a;
    end_value_i    <= b;
    blend_weight_i <= weight;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    entry.mode    = blend_mode;
    entry.start_v = a;
    entry.end_v   = b;
    entry.weight  = weight;
    entry.result  = known ? result : eased_blend(blend_mode, a, b, weight);
    pending_blends.push_back(entry);
  endtask

  function automatic logic [VALUE_WIDTH-1:0] random_endpoint();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'($urandom_range(3)) - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] random_weight();
    case ($urandom_range(19))
      0:       return '0;
      1:       return WEIGHT_ONE;
      2, 3:    return 17'($urandom_range(131071, 65537));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    pending_blend_t exp_item;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_blends.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected blend result %0d at %0t", blended_value_o, $realtime);
      end else begin
        exp_item = pending_blends.pop_front();
        if (blended_value_o !== exp_item.result) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("blend mismatch: mode %0d a %0d b %0d w %0d expected %0d got %0d",
                     exp_item.mode, $signed(exp_item.start_v), $signed(exp_item.end_v),
                     exp_item.weight, $signed(exp_item.result), blended_value_o);
        end
      end
    end
  end

  initial begin
    logic [MODE_W-1:0] phase_mode;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].mode != blend_mode) write_mode(DIRECTED[i].mode);
      send_blend(DIRECTED[i].start_v, DIRECTED[i].end_v, DIRECTED[i].weight,
                 DIRECTED[i].known, DIRECTED[i].result);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       phase_mode = MODE_COSINE;
        1:       phase_mode = MODE_TRUNC;
        2:       phase_mode = MODE_QUINTIC;
        3:       phase_mode = MODE_CUBIC;
        4:       phase_mode = MODE_UNUSED_HI;
        5:       phase_mode = MODE_LINEAR;
        default: phase_mode = 3'($urandom_range(7));
      endcase
      if (phase < 3) begin
        send_idle_pct  = 8;
        recv_stall_pct = 83;
      end else if (phase < 6) begin
        send_idle_pct  = 83;
        recv_stall_pct = 8;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      write_mode(phase_mode);
      repeat (PHASE_ITEMS) send_blend(random_endpoint(), random_endpoint(), random_weight(),
                                      1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (pending_blends.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_blends.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bint_pkg.sv
rtl/bint_cos_rom.sv
rtl/bint_ease.sv
rtl/bint_blend.sv
rtl/blend_interpolator_top.sv
dv/tb_blend_interpolator_top.sv
